### rtl/core/rih_pkg.sv
package rih_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned IdW    = 10;
  localparam int unsigned ListW  = 2;
  localparam int unsigned TotalW = 11;
  localparam int unsigned CountW = 2;

  localparam logic [CountW-1:0] CountMax = 2'd3;

  // Identifier store depth and command queue depth
  localparam int unsigned DefIdSpace = 1024;
  localparam int unsigned QueueDepth = 2;

  // Input mode codes
  localparam logic [ModeW-1:0] MODE_ADD   = 2'd0;
  localparam logic [ModeW-1:0] MODE_COUNT = 2'd1;
  localparam logic [ModeW-1:0] MODE_FIND  = 2'd2;

  // Classified operations handed from front to back
  typedef enum logic [1:0] {
    OP_ADD,
    OP_COUNT,
    OP_FIND,
    OP_MISS
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdW-1:0]   id;
    logic             mark_en;
  } cmd_t;

  typedef struct packed {
    logic              mark;
    logic [CountW-1:0] count;
  } entry_t;

endpackage

### rtl/core/rih_if.sv
interface rih_in_if;
  logic                        valid;
  logic                        ready;
  logic [rih_pkg::ModeW-1:0]   mode;
  logic [rih_pkg::IdW-1:0]     voter_id;
  logic [rih_pkg::ListW-1:0]   list_number;

  modport source (output valid, mode, voter_id, list_number, input ready);
  modport sink   (input valid, mode, voter_id, list_number, output ready);
endinterface

interface rih_out_if;
  logic                        valid;
  logic                        ready;
  logic [rih_pkg::TotalW-1:0]  marked_total;
  logic [rih_pkg::IdW-1:0]     found_id;
  logic                        found;

  modport source (output valid, marked_total, found_id, found, input ready);
  modport sink   (input valid, marked_total, found_id, found, output ready);
endinterface

### rtl/core/rih_front.sv
module rih_front #(
  parameter int unsigned ID_SPACE = rih_pkg::DefIdSpace
) (
  rih_in_if.sink         in_i,
  output logic           push_o,
  output rih_pkg::cmd_t  cmd_o,
  input  logic           push_ready_i
);
  import rih_pkg::*;

  logic        keep;
  logic [31:0] id_ext;
  logic        id_in_range;

  assign id_ext      = 32'(in_i.voter_id);
  assign id_in_range = id_ext < ID_SPACE;

  // Classify the item; drop adds outside the store and unknown modes
  always_comb begin
    keep          = 1'b1;
    cmd_o.op      = OP_COUNT;
    cmd_o.id      = in_i.voter_id;
    cmd_o.mark_en = (in_i.list_number != '0);
    unique case (in_i.mode)
      MODE_ADD: begin
        cmd_o.op = OP_ADD;
        keep     = id_in_range;
      end
      MODE_COUNT: begin
        cmd_o.op = OP_COUNT;
      end
      MODE_FIND: begin
        cmd_o.op = id_in_range ? OP_FIND : OP_MISS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_i.ready = push_ready_i;
  assign push_o     = in_i.valid && push_ready_i && keep;

endmodule

### rtl/core/rih_queue.sv
module rih_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rih_pkg::cmd_t  push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output rih_pkg::cmd_t  pop_cmd_o,
  input  logic           pop_i
);
  import rih_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign push_ready_o = (fill_q != CntW'(QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/core/rih_back.sv
module rih_back #(
  parameter int unsigned ID_SPACE = rih_pkg::DefIdSpace
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  rih_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  rih_out_if.source      out_o
);
  import rih_pkg::*;

  localparam int unsigned IdxW    = $clog2(ID_SPACE);
  localparam int unsigned ScanEnd = (ID_SPACE < (1 << IdW)) ? ID_SPACE : (1 << IdW);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ID_SPACE - 1);
  localparam logic [IdxW-1:0] ScanLast = IdxW'(ScanEnd - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_FIND
  } state_e;

  state_e            state_q;
  logic [IdxW-1:0]   clr_idx_q;
  logic [IdxW-1:0]   chk_idx_q;
  logic              mark_en_q;
  logic [TotalW-1:0] total_q;
  logic              out_valid_q;
  logic [TotalW-1:0] out_total_q;
  logic [IdW-1:0]    out_id_q;
  logic              out_found_q;

  entry_t            mem_q [ID_SPACE];
  entry_t            rd_q;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;

  logic [31:0]       cmd_id_ext;
  logic [IdxW-1:0]   cmd_idx;
  logic [31:0]       chk_ext;
  logic              out_free;
  logic [CountW-1:0] cnt_next;
  logic              set_mark;

  assign cmd_id_ext = 32'(cmd_i.id);
  assign cmd_idx    = cmd_id_ext[IdxW-1:0];
  assign chk_ext    = 32'(chk_idx_q);
  assign out_free   = !out_valid_q || out_o.ready;

  // Adds never produce a result, so only queries wait for the output slot
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i &&
                     ((cmd_i.op == OP_ADD) || out_free);

  // Read-modify-write of one entry
  assign cnt_next = (rd_q.count == CountMax) ? rd_q.count : rd_q.count + 1'b1;
  assign set_mark = mark_en_q && (cnt_next > CountW'(1)) && !rd_q.mark;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cmd_idx;
    if (state_q == S_IDLE) begin
      rd_en = cmd_pop_o && ((cmd_i.op == OP_ADD) || (cmd_i.op == OP_FIND));
    end else if (state_q == S_FIND) begin
      rd_en   = !rd_q.mark && (chk_idx_q != ScanLast);
      rd_addr = chk_idx_q + 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_idx_q;
    wr_data = '0;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
    end else if (state_q == S_ADD) begin
      wr_en         = 1'b1;
      wr_data.count = cnt_next;
      wr_data.mark  = rd_q.mark || set_mark;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (clr_idx_q == LastIdx) begin
            state_q <= S_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.op)
              OP_ADD: begin
                chk_idx_q <= cmd_idx;
                mark_en_q <= cmd_i.mark_en;
                state_q   <= S_ADD;
              end
              OP_FIND: begin
                chk_idx_q <= cmd_idx;
                state_q   <= S_FIND;
              end
              OP_COUNT, OP_MISS: begin
                out_valid_q <= 1'b1;
                out_total_q <= total_q;
                out_id_q    <= '0;
                out_found_q <= 1'b0;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (set_mark) begin
            total_q <= total_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_FIND: begin
          if (rd_q.mark) begin
            out_valid_q <= 1'b1;
            out_total_q <= total_q;
            out_id_q    <= chk_ext[IdW-1:0];
            out_found_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (chk_idx_q == ScanLast) begin
            out_valid_q <= 1'b1;
            out_total_q <= total_q;
            out_id_q    <= '0;
            out_found_q <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            chk_idx_q <= chk_idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.marked_total = out_total_q;
  assign out_o.found_id     = out_id_q;
  assign out_o.found        = out_found_q;

endmodule

### rtl/core/repeated_id_histogram.sv
// Repeated-identifier histogram.
// in_i carries items: mode (add, count query, find query), voter_id and
// list_number. out_o carries one result per query: marked_total, found_id
// and found. Adds and items with an unknown mode produce no result.
// Items pass a front classifier into a two-entry command queue; the back
// end owns the per-identifier store (count and mark, one memory port).
// Back end: an add reads its entry, then writes it back; a count query is
// answered straight from the idle state. A find reads one mark per cycle
// from the start value upward and stops at the first mark, or at
// min(ID_SPACE, 1024) - 1 when nothing matches. From accept to result,
// a count query passes the queue slot, then the output register; a find
// also passes its scan of the store.
// Reset: the back end clears the store, one entry per cycle, through all
// ID_SPACE entries; items are still taken until the queue fills.
// Receiver stall: the result stays in the output register; adds keep
// draining, and the next query waits in the queue, backing up in_i.ready.
module repeated_id_histogram #(
  parameter int unsigned ID_SPACE = rih_pkg::DefIdSpace
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rih_in_if.sink    in_i,
  rih_out_if.source out_o
);
  import rih_pkg::*;

  // Front to queue
  logic push;
  logic push_ready;
  cmd_t push_cmd;

  // Queue to back
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  // Classify items and drop those with no effect
  rih_front #(
    .ID_SPACE (ID_SPACE)
  ) u_front (
    .in_i         (in_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .push_ready_i (push_ready)
  );

  // Decouple classification from execution
  rih_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  // Execute adds, queries and scans against the store
  rih_back #(
    .ID_SPACE (ID_SPACE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

### sim/rih_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the identifier store and
// compares each result with the oldest pending answer.
module rih_checker
  import rih_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rih_in_if           in_mon,
  rih_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned IdSpace = DefIdSpace;
  localparam logic [ListW-1:0] ListFirst = '0;

  typedef struct packed {
    logic [TotalW-1:0] marked_total;
    logic [IdW-1:0]    found_id;
    logic              found;
  } answer_t;

  logic [CountW-1:0] seen_count [IdSpace];
  logic              mark_bit   [IdSpace];
  logic [TotalW-1:0] marked_sum;
  answer_t           expected_answers [$];
  answer_t           oldest;
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Apply one accepted item to the shadow store; queue an answer for queries.
  task automatic absorb_item(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                             input logic [ListW-1:0] list);
    answer_t           ans;
    logic [CountW-1:0] cnt;
    ans              = '0;
    ans.marked_total = marked_sum;
    case (mode)
      MODE_ADD: begin
        if (int'(id) < IdSpace) begin
          cnt = seen_count[id];
          if (cnt != CountMax) cnt++;
          seen_count[id] = cnt;
          if (list != ListFirst && cnt > 1 && !mark_bit[id]) begin
            mark_bit[id] = 1'b1;
            marked_sum++;
          end
        end
      end
      MODE_COUNT: expected_answers.push_back(ans);
      MODE_FIND: begin
        for (int i = int'(id); i < int'(IdSpace); i++) begin
          if (mark_bit[i]) begin
            ans.found_id = i[IdW-1:0];
            ans.found    = 1'b1;
            break;
          end
        end
        expected_answers.push_back(ans);
      end
      default: ;  // unused mode: drop
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(IdSpace); i++) begin
        seen_count[i] = '0;
        mark_bit[i]   = 1'b0;
      end
      marked_sum = '0;
      expected_answers.delete();
    end else begin
      // Results first, so a query accepted on this edge is not matched early.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result total", out_mon.marked_total, 0);
        end else begin
          oldest = expected_answers.pop_front();
          if (out_mon.marked_total !== oldest.marked_total)
            report_mismatch("marked_total", out_mon.marked_total, oldest.marked_total);
          if (out_mon.found_id !== oldest.found_id)
            report_mismatch("found_id", out_mon.found_id, oldest.found_id);
          if (out_mon.found !== oldest.found)
            report_mismatch("found", out_mon.found, oldest.found);
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_item(in_mon.mode, in_mon.voter_id, in_mon.list_number);
    end
    pending_o = expected_answers.size();
  end

endmodule

### sim/tb_repeated_id_histogram.sv
`timescale 1ns / 1ps

module tb_repeated_id_histogram;
  import rih_pkg::*;

  // Cycles without any handshake before the run is declared hung. The slowest
  // honest stretch is the store clear after reset (one entry per cycle) or a
  // full-range find scan, plus a receiver stall.
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned RandomItems = 1080;
  localparam int unsigned IdlePct     = 27;
  localparam int unsigned DrainCycles = 40;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam logic [ListW-1:0] ListFirst  = 2'd0;
  localparam logic [ListW-1:0] ListSecond = 2'd1;
  localparam logic [ListW-1:0] ListThird  = 2'd2;
  localparam logic [ListW-1:0] ListExtra  = 2'd3;

  logic           clk_i;
  logic           rst_ni;
  logic           steady;      // high: neither side idles
  logic [IdW-1:0] pool_base;   // hot window of ids, so repeats are common
  int unsigned    fail_count;
  int unsigned    pending_answers;
  int unsigned    quiet_cycles;

  rih_in_if  in_ch ();
  rih_out_if out_ch ();

  repeated_id_histogram dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rih_checker answer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_answers)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Stall the result side at random, except during the steady stretch.
  always @(negedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("%0t ns: no handshake for %0d cycles", $realtime, StallLimit);
    $display("FAIL");
    $finish;
  end

  // Offer one item from a falling edge and hold it until accepted; return on
  // the falling edge after the accepting rising edge.
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                           input logic [ListW-1:0] list);
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.voter_id    <= id;
    in_ch.list_number <= list;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Hold the sender until every query has been answered.
  task automatic wait_for_answers();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_answers != 0);
  endtask

  // Mostly ids near the hot window, the rest anywhere in the id space.
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(99) < 70) return pool_base + IdW'($urandom_range(47));
    return IdW'($urandom);
  endfunction

  function automatic logic [IdW-1:0] pick_start();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return pool_base + IdW'($urandom_range(47));
    if (r < 65) return '0;
    return IdW'($urandom);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned r;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_ADD;
    in_ch.voter_id    = '0;
    in_ch.list_number = ListFirst;
    out_ch.ready      = 1'b0;
    steady            = 1'b0;
    pool_base         = '0;
    rst_ni            = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty store, then the marking rules one by one.
    send_item(MODE_COUNT, '0, ListFirst);          // nothing marked yet
    send_item(MODE_FIND, '0, ListFirst);           // find on empty store misses
    send_item(MODE_FIND, '1, ListExtra);           // highest start, no match
    send_item(MODE_ADD, '1, ListFirst);
    send_item(MODE_ADD, '1, ListFirst);            // repeat from first list: no mark
    send_item(MODE_FIND, '0, ListFirst);
    send_item(MODE_ADD, '1, ListSecond);           // marks the top id
    send_item(MODE_ADD, '1, ListThird);            // count saturates, mark holds
    send_item(MODE_FIND, '1, ListFirst);           // find at the top id itself
    send_item(MODE_FIND, '0, ListFirst);           // long scan up to the top
    send_item(MODE_ADD, '0, ListExtra);
    send_item(MODE_ADD, '0, ListExtra);            // list number 3 also marks
    send_item(MODE_COUNT, '1, ListExtra);          // query ignores id and list
    send_item(MODE_FIND, '0, ListFirst);
    send_item(MODE_FIND, 10'd1, ListFirst);
    send_item(ModeUnused, 10'd5, ListSecond);      // unused mode: ignored
    send_item(ModeUnused, 10'd5, ListSecond);
    send_item(MODE_ADD, 10'd5, ListThird);         // first real add of 5: no mark
    send_item(MODE_FIND, 10'd1, ListFirst);
    send_item(MODE_ADD, 10'h2AA, ListSecond);
    send_item(MODE_ADD, 10'h2AA, ListFirst);       // second add, but first list
    send_item(MODE_ADD, 10'h155, ListFirst);
    send_item(MODE_ADD, 10'h155, ListThird);       // marks
    send_item(MODE_COUNT, '0, ListFirst);
    send_item(MODE_FIND, 10'h156, ListSecond);     // skips the unmarked 0x2AA
    wait_for_answers();

    // Random: adds clustered in a moving window, queries with varied starts.
    sent = 0;
    while (sent < RandomItems) begin
      steady <= (sent >= 300 && sent < 480);
      if (sent % 150 == 0) pool_base = IdW'($urandom);
      if (sent == 700) wait_for_answers();
      r = $urandom_range(99);
      if (r < 55) begin
        send_item(MODE_ADD, pick_id(), ListW'($urandom_range(3)));
      end else if (r < 70) begin
        send_item(MODE_COUNT, IdW'($urandom), ListW'($urandom_range(3)));
      end else if (r < 95) begin
        send_item(MODE_FIND, pick_start(), ListW'($urandom_range(3)));
      end else begin
        send_item(ModeUnused, IdW'($urandom), ListW'($urandom_range(3)));
      end
      if (r < 95) sent++;
    end
    in_ch.valid <= 1'b0;

    // Drain: let every query answer, then leave room for stray results.
    while (pending_answers != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
